@@ design/lsts_pkg.sv @@
// shared types, opcodes and the instruction decoder for the load/store/transfer core
package lsts_pkg;

    // default memory address width
    localparam int ADDR_BITS_DEF = 16;

    // request modes
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_EXEC  = 2'd2;

    // supported opcodes
    localparam logic [7:0] OP_LDA_IMM = 8'hA9;
    localparam logic [7:0] OP_LDA_ZP  = 8'hA5;
    localparam logic [7:0] OP_LDA_ABS = 8'hAD;
    localparam logic [7:0] OP_LDX_IMM = 8'hA2;
    localparam logic [7:0] OP_LDX_ZP  = 8'hA6;
    localparam logic [7:0] OP_LDX_ABS = 8'hAE;
    localparam logic [7:0] OP_LDY_IMM = 8'hA0;
    localparam logic [7:0] OP_LDY_ZP  = 8'hA4;
    localparam logic [7:0] OP_LDY_ABS = 8'hAC;
    localparam logic [7:0] OP_STA_ZP  = 8'h85;
    localparam logic [7:0] OP_STA_ABS = 8'h8D;
    localparam logic [7:0] OP_STX_ZP  = 8'h86;
    localparam logic [7:0] OP_STX_ABS = 8'h8E;
    localparam logic [7:0] OP_STY_ZP  = 8'h84;
    localparam logic [7:0] OP_STY_ABS = 8'h8C;
    localparam logic [7:0] OP_TAX     = 8'hAA;
    localparam logic [7:0] OP_TAY     = 8'hA8;
    localparam logic [7:0] OP_TSX     = 8'hBA;
    localparam logic [7:0] OP_TXA     = 8'h8A;
    localparam logic [7:0] OP_TXS     = 8'h9A;
    localparam logic [7:0] OP_TYA     = 8'h98;

    // input request payload
    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] address;
        logic [7:0]  write_data;
    } in_t;

    // result payload
    typedef struct packed {
        logic [7:0]  read_data;
        logic        status;
        logic [7:0]  acc_value;
        logic [7:0]  index_x_value;
        logic [7:0]  index_y_value;
        logic [7:0]  stack_value;
        logic [15:0] program_counter;
        logic        negative_flag;
        logic        zero_flag;
    } out_t;

    typedef enum logic [1:0] {K_BAD, K_LOAD, K_STORE, K_XFER} op_kind_t;
    typedef enum logic [1:0] {AM_IMM, AM_ZP, AM_ABS} addr_mode_t;
    typedef enum logic [1:0] {SEL_A, SEL_X, SEL_Y, SEL_S} reg_sel_t;

    // decoded instruction
    typedef struct packed {
        op_kind_t   kind;
        addr_mode_t am;
        reg_sel_t   dst;
        reg_sel_t   src;
        logic       set_nz;
    } op_info_t;

    function automatic op_info_t decode_op(input logic [7:0] op);
        op_info_t info;
        info.kind   = K_BAD;
        info.am     = AM_IMM;
        info.dst    = SEL_A;
        info.src    = SEL_A;
        info.set_nz = 1'b1;
        unique case (op)
            OP_LDA_IMM: begin info.kind = K_LOAD;  info.am = AM_IMM; info.dst = SEL_A; end
            OP_LDA_ZP:  begin info.kind = K_LOAD;  info.am = AM_ZP;  info.dst = SEL_A; end
            OP_LDA_ABS: begin info.kind = K_LOAD;  info.am = AM_ABS; info.dst = SEL_A; end
            OP_LDX_IMM: begin info.kind = K_LOAD;  info.am = AM_IMM; info.dst = SEL_X; end
            OP_LDX_ZP:  begin info.kind = K_LOAD;  info.am = AM_ZP;  info.dst = SEL_X; end
            OP_LDX_ABS: begin info.kind = K_LOAD;  info.am = AM_ABS; info.dst = SEL_X; end
            OP_LDY_IMM: begin info.kind = K_LOAD;  info.am = AM_IMM; info.dst = SEL_Y; end
            OP_LDY_ZP:  begin info.kind = K_LOAD;  info.am = AM_ZP;  info.dst = SEL_Y; end
            OP_LDY_ABS: begin info.kind = K_LOAD;  info.am = AM_ABS; info.dst = SEL_Y; end
            OP_STA_ZP:  begin info.kind = K_STORE; info.am = AM_ZP;  info.src = SEL_A; end
            OP_STA_ABS: begin info.kind = K_STORE; info.am = AM_ABS; info.src = SEL_A; end
            OP_STX_ZP:  begin info.kind = K_STORE; info.am = AM_ZP;  info.src = SEL_X; end
            OP_STX_ABS: begin info.kind = K_STORE; info.am = AM_ABS; info.src = SEL_X; end
            OP_STY_ZP:  begin info.kind = K_STORE; info.am = AM_ZP;  info.src = SEL_Y; end
            OP_STY_ABS: begin info.kind = K_STORE; info.am = AM_ABS; info.src = SEL_Y; end
            OP_TAX:     begin info.kind = K_XFER;  info.dst = SEL_X; info.src = SEL_A; end
            OP_TAY:     begin info.kind = K_XFER;  info.dst = SEL_Y; info.src = SEL_A; end
            OP_TSX:     begin info.kind = K_XFER;  info.dst = SEL_X; info.src = SEL_S; end
            OP_TXA:     begin info.kind = K_XFER;  info.dst = SEL_A; info.src = SEL_X; end
            OP_TXS:
            begin
                info.kind   = K_XFER;
                info.dst    = SEL_S;
                info.src    = SEL_X;
                info.set_nz = 1'b0;
            end
            OP_TYA:     begin info.kind = K_XFER;  info.dst = SEL_A; info.src = SEL_Y; end
            default:    info.kind = K_BAD;
        endcase
        return info;
    endfunction

endpackage

@@ design/lsts_ram.sv @@
// single-port byte memory with a registered read port
module lsts_ram #(
    parameter int ADDR_BITS = 16
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] addr,
    input  logic [7:0]           wdata,
    output logic [7:0]           rdata
);

    logic [7:0] byte_mem [2**ADDR_BITS];
    logic [7:0] rdata_reg;

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                byte_mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= byte_mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/cpu_load_store_transfer_subset_core.sv @@
// top level: sequencer, register file and result register of the load/store/transfer core
//
//  channel | signals                      | direction | payload
//  --------+------------------------------+-----------+--------------------------
//  in      | in_valid, in_ready, in_data  | into core | mode, address, write_data
//  out     | out_valid, out_ready, out_data | out     | read_data, status, registers
//
// a host write or unknown mode ends in the completion step, a host read in the read-return step;
// an execute fetches the opcode, then any operand bytes, then for zero-page or absolute the data
// access; the next request is taken in the cycle the current result is registered.
// the single memory port takes one access a cycle and has a registered read.
// after reset the memory is cleared one byte a cycle, with in_ready low until every byte is written.
// a full result register stalls only the completing step; earlier steps keep going.
module cpu_load_store_transfer_subset_core
    import lsts_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_OP,
        ST_ARG1,
        ST_ARG2,
        ST_DATA,
        ST_HRD,
        ST_FIN
    } state_t;

    state_t               state_reg, state_next;
    logic [ADDR_BITS-1:0] clr_reg, clr_next;
    logic [15:0]          pc_reg, pc_next;
    logic [7:0]           op_reg, op_next;
    logic [7:0]           lo_reg, lo_next;
    logic [7:0]           acc_reg, acc_next;
    logic [7:0]           x_reg, x_next;
    logic [7:0]           y_reg, y_next;
    logic [7:0]           sp_reg, sp_next;
    logic                 neg_reg, neg_next;
    logic                 zero_reg, zero_next;
    logic                 out_valid_reg, out_valid_next;
    out_t                 out_data_reg, out_data_next;

    logic                 mem_en, mem_we;
    logic [ADDR_BITS-1:0] mem_addr;
    logic [7:0]           mem_wdata, mem_rdata;

    logic                 slot_free, done, push, accept;
    logic [7:0]           op_cur;
    op_info_t             info;
    logic [7:0]           src_val;
    logic [15:0]          abs_addr;
    logic [7:0]           res_rd;
    logic                 res_st;
    logic                 upd_en, upd_nz;
    reg_sel_t             upd_sel;
    logic [7:0]           upd_val;

    lsts_ram #(.ADDR_BITS(ADDR_BITS)) u_ram (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // decode straight from the memory in the opcode step, from the saved opcode after
    assign op_cur   = (state_reg == ST_OP) ? mem_rdata : op_reg;
    assign info     = decode_op(op_cur);
    assign abs_addr = {mem_rdata, lo_reg};

    // source register select
    always_comb
    begin
        case (info.src)
            SEL_A:   src_val = acc_reg;
            SEL_X:   src_val = x_reg;
            SEL_Y:   src_val = y_reg;
            default: src_val = sp_reg;
        endcase
    end

    assign slot_free = !out_valid_reg || out_ready;
    assign push      = done && slot_free;
    assign in_ready  = (state_reg == ST_IDLE) || push;
    assign accept    = in_valid && in_ready;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        pc_next    = pc_reg;
        op_next    = op_reg;
        lo_next    = lo_reg;
        mem_en     = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = pc_reg[ADDR_BITS-1:0];
        mem_wdata  = src_val;
        done       = 1'b0;
        res_rd     = 8'd0;
        res_st     = 1'b0;
        upd_en     = 1'b0;
        upd_sel    = info.dst;
        upd_val    = mem_rdata;
        upd_nz     = info.set_nz;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = 8'd0;
                clr_next  = clr_reg + ADDR_BITS'(1);
                if (clr_reg == {ADDR_BITS{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
            end
            ST_OP:
            begin
                op_next = mem_rdata;
                case (info.kind) inside
                    K_LOAD, K_STORE:
                    begin
                        mem_en     = 1'b1;
                        pc_next    = pc_reg + 16'd1;
                        state_next = ST_ARG1;
                    end
                    K_XFER:
                    begin
                        done    = 1'b1;
                        upd_en  = 1'b1;
                        upd_val = src_val;
                    end
                    default:
                    begin
                        done   = 1'b1;
                        res_st = 1'b1;
                    end
                endcase
            end
            ST_ARG1:
            begin
                if (info.am == AM_IMM)
                begin
                    done   = 1'b1;
                    upd_en = 1'b1;
                end
                else if (info.am == AM_ZP)
                begin
                    mem_en   = 1'b1;
                    mem_we   = (info.kind == K_STORE);
                    mem_addr = ADDR_BITS'(mem_rdata);
                    state_next = (info.kind == K_STORE) ? ST_FIN : ST_DATA;
                end
                else
                begin
                    lo_next    = mem_rdata;
                    mem_en     = 1'b1;
                    pc_next    = pc_reg + 16'd1;
                    state_next = ST_ARG2;
                end
            end
            ST_ARG2:
            begin
                mem_en     = 1'b1;
                mem_we     = (info.kind == K_STORE);
                mem_addr   = abs_addr[ADDR_BITS-1:0];
                state_next = (info.kind == K_STORE) ? ST_FIN : ST_DATA;
            end
            ST_DATA:
            begin
                done   = 1'b1;
                upd_en = 1'b1;
            end
            ST_HRD:
            begin
                done   = 1'b1;
                res_rd = mem_rdata;
            end
            ST_FIN:
            begin
                done = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (push)
        begin
            state_next = ST_IDLE;
        end

        // dispatch a new request; completing steps never use the memory port
        if (accept)
        begin
            case (in_data.mode)
                MODE_WRITE:
                begin
                    mem_en     = 1'b1;
                    mem_we     = 1'b1;
                    mem_addr   = in_data.address[ADDR_BITS-1:0];
                    mem_wdata  = in_data.write_data;
                    state_next = ST_FIN;
                end
                MODE_READ:
                begin
                    mem_en     = 1'b1;
                    mem_we     = 1'b0;
                    mem_addr   = in_data.address[ADDR_BITS-1:0];
                    state_next = ST_HRD;
                end
                MODE_EXEC:
                begin
                    mem_en     = 1'b1;
                    mem_we     = 1'b0;
                    mem_addr   = pc_reg[ADDR_BITS-1:0];
                    pc_next    = pc_reg + 16'd1;
                    state_next = ST_OP;
                end
                default:
                begin
                    state_next = ST_FIN;
                end
            endcase
        end
    end

    // register file update at completion
    always_comb
    begin
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        sp_next   = sp_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        if (push && upd_en)
        begin
            case (upd_sel)
                SEL_A:   acc_next = upd_val;
                SEL_X:   x_next   = upd_val;
                SEL_Y:   y_next   = upd_val;
                default: sp_next  = upd_val;
            endcase
            if (upd_nz)
            begin
                neg_next  = upd_val[7];
                zero_next = (upd_val == 8'd0);
            end
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = push ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
        out_data_next  = out_data_reg;
        if (push)
        begin
            out_data_next.read_data       = res_rd;
            out_data_next.status          = res_st;
            out_data_next.acc_value       = acc_next;
            out_data_next.index_x_value   = x_next;
            out_data_next.index_y_value   = y_next;
            out_data_next.stack_value     = sp_next;
            out_data_next.program_counter = pc_reg;
            out_data_next.negative_flag   = neg_next;
            out_data_next.zero_flag       = zero_next;
        end
    end

    // state, architectural registers and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            pc_reg        <= 16'd0;
            op_reg        <= 8'd0;
            lo_reg        <= 8'd0;
            acc_reg       <= 8'd0;
            x_reg         <= 8'd0;
            y_reg         <= 8'd0;
            sp_reg        <= 8'd0;
            neg_reg       <= 1'b0;
            zero_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pc_reg        <= pc_next;
            op_reg        <= op_next;
            lo_reg        <= lo_next;
            acc_reg       <= acc_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            sp_reg        <= sp_next;
            neg_reg       <= neg_next;
            zero_reg      <= zero_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // no request taken while memory is being cleared
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !in_ready)
        else $error("request accepted during memory clear");

    // an execute request fetches the opcode and bumps the pc
    a_exec_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_data.mode == MODE_EXEC))
            |=> ((state_reg == ST_OP) && (pc_reg == $past(pc_reg) + 16'd1)))
        else $error("execute dispatch did not fetch the opcode");

    // every functional memory write is followed by the plain completion step
    a_write_then_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_en && mem_we && (state_reg != ST_CLEAR)) |=> (state_reg == ST_FIN))
        else $error("memory write not followed by completion");

    // an error status only comes from the opcode step
    a_status_source: assert property (@(posedge clk) disable iff (!rst_n)
        (push && res_st) |-> (state_reg == ST_OP))
        else $error("error status outside opcode decode");

    // a result is never registered over one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !push)
        else $error("result register overwritten");

endmodule

@@ tb/tb_top.sv @@
// self-checking testbench for the load/store/transfer cpu core with its own register-level predictor
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lsts_pkg::*;

    // mode value the core ignores
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    // cycles without any handshake before the run is declared hung (covers the memory clear)
    localparam int STALL_LIMIT = 200000;
    // requests in the first and second random parts, counted from the start
    localparam int PART_A_END = 825;
    localparam int PART_B_END = 1650;

    localparam logic [7:0] KNOWN_OPS [0:20] = '{
        OP_LDA_IMM, OP_LDA_ZP, OP_LDA_ABS, OP_LDX_IMM, OP_LDX_ZP, OP_LDX_ABS,
        OP_LDY_IMM, OP_LDY_ZP, OP_LDY_ABS, OP_STA_ZP, OP_STA_ABS, OP_STX_ZP,
        OP_STX_ABS, OP_STY_ZP, OP_STY_ABS, OP_TAX, OP_TAY, OP_TSX, OP_TXA,
        OP_TXS, OP_TYA
    };

    // one request with the register state it should leave behind
    typedef struct packed {
        in_t  req;
        out_t result;
    } cpu_request_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_t  in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_data;

    cpu_request_t request_q[$];
    out_t         due_results_q[$];

    int queued_count = 0;
    int accepted_count = 0;
    int result_count = 0;
    int error_count = 0;
    int stall_cycles = 0;
    int holdoff_left = 0;
    bit holdoff_done = 1'b0;

    // emulated cpu state
    logic [7:0]  cpu_mem [0:65535];
    logic [7:0]  cpu_a;
    logic [7:0]  cpu_x;
    logic [7:0]  cpu_y;
    logic [7:0]  cpu_s;
    logic [15:0] cpu_pc;
    logic        cpu_n;
    logic        cpu_z;

    cpu_load_store_transfer_subset_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // reset, once
    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    task automatic flag_error(input string msg);
        error_count++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    // instruction stream fetch, pc wraps at 16 bits
    function automatic logic [7:0] fetch_code();
        logic [7:0] b;
        b = cpu_mem[cpu_pc];
        cpu_pc = cpu_pc + 16'd1;
        return b;
    endfunction

    // zero-page or little-endian absolute operand
    function automatic logic [15:0] operand_address(input bit absolute);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = fetch_code();
        hi = 8'h00;
        if (absolute)
            hi = fetch_code();
        return {hi, lo};
    endfunction

    function automatic void set_flags(input logic [7:0] v);
        cpu_n = v[7];
        cpu_z = (v == 8'h00);
    endfunction

    function automatic logic [7:0] load_value(input addr_mode_t am);
        logic [7:0] v;
        case (am)
            AM_IMM:  v = fetch_code();
            AM_ZP:   v = cpu_mem[operand_address(1'b0)];
            default: v = cpu_mem[operand_address(1'b1)];
        endcase
        set_flags(v);
        return v;
    endfunction

    // one instruction at pc, returns the unknown-opcode status
    function automatic logic execute_instr();
        logic [7:0] op;
        logic       bad;
        op = fetch_code();
        bad = 1'b0;
        case (op)
            OP_LDA_IMM: cpu_a = load_value(AM_IMM);
            OP_LDA_ZP:  cpu_a = load_value(AM_ZP);
            OP_LDA_ABS: cpu_a = load_value(AM_ABS);
            OP_LDX_IMM: cpu_x = load_value(AM_IMM);
            OP_LDX_ZP:  cpu_x = load_value(AM_ZP);
            OP_LDX_ABS: cpu_x = load_value(AM_ABS);
            OP_LDY_IMM: cpu_y = load_value(AM_IMM);
            OP_LDY_ZP:  cpu_y = load_value(AM_ZP);
            OP_LDY_ABS: cpu_y = load_value(AM_ABS);
            OP_STA_ZP:  cpu_mem[operand_address(1'b0)] = cpu_a;
            OP_STA_ABS: cpu_mem[operand_address(1'b1)] = cpu_a;
            OP_STX_ZP:  cpu_mem[operand_address(1'b0)] = cpu_x;
            OP_STX_ABS: cpu_mem[operand_address(1'b1)] = cpu_x;
            OP_STY_ZP:  cpu_mem[operand_address(1'b0)] = cpu_y;
            OP_STY_ABS: cpu_mem[operand_address(1'b1)] = cpu_y;
            OP_TAX:
            begin
                cpu_x = cpu_a;
                set_flags(cpu_a);
            end
            OP_TAY:
            begin
                cpu_y = cpu_a;
                set_flags(cpu_a);
            end
            OP_TSX:
            begin
                cpu_x = cpu_s;
                set_flags(cpu_s);
            end
            OP_TXA:
            begin
                cpu_a = cpu_x;
                set_flags(cpu_x);
            end
            // stack pointer load leaves the flags alone
            OP_TXS:     cpu_s = cpu_x;
            OP_TYA:
            begin
                cpu_a = cpu_y;
                set_flags(cpu_y);
            end
            default:    bad = 1'b1;
        endcase
        return bad;
    endfunction

    // apply one request to the emulated cpu and return the registers it reports
    function automatic out_t emulate_item(input in_t req);
        out_t r;
        r = '0;
        case (req.mode)
            MODE_WRITE: cpu_mem[req.address] = req.write_data;
            MODE_READ:  r.read_data = cpu_mem[req.address];
            MODE_EXEC:  r.status = execute_instr();
            default:    ;
        endcase
        r.acc_value       = cpu_a;
        r.index_x_value   = cpu_x;
        r.index_y_value   = cpu_y;
        r.stack_value     = cpu_s;
        r.program_counter = cpu_pc;
        r.negative_flag   = cpu_n;
        r.zero_flag       = cpu_z;
        return r;
    endfunction

    function automatic void queue_request(input logic [1:0] mode, input logic [15:0] addr,
                                          input logic [7:0] data);
        cpu_request_t e;
        e.req.mode       = mode;
        e.req.address    = addr;
        e.req.write_data = data;
        e.result         = emulate_item(e.req);
        request_q.push_back(e);
        queued_count++;
    endfunction

    // place an instruction at pc with host writes, then execute it
    function automatic void queue_instr(input logic [7:0] op, input logic [7:0] b1,
                                        input logic [7:0] b2);
        int n;
        case (op)
            OP_LDA_IMM, OP_LDX_IMM, OP_LDY_IMM, OP_LDA_ZP, OP_LDX_ZP, OP_LDY_ZP,
            OP_STA_ZP, OP_STX_ZP, OP_STY_ZP:
                n = 2;
            OP_LDA_ABS, OP_LDX_ABS, OP_LDY_ABS, OP_STA_ABS, OP_STX_ABS, OP_STY_ABS:
                n = 3;
            default:
                n = 1;
        endcase
        queue_request(MODE_WRITE, cpu_pc, op);
        if (n > 1)
            queue_request(MODE_WRITE, cpu_pc + 16'd1, b1);
        if (n > 2)
            queue_request(MODE_WRITE, cpu_pc + 16'd2, b2);
        queue_request(MODE_EXEC, 16'($urandom), 8'($urandom));
    endfunction

    // addresses that hit the same bytes often, so stores and loads meet
    function automatic logic [15:0] hot_address();
        logic [15:0] a;
        a = 16'($urandom);
        if ($urandom_range(0, 1) == 1)
            a[7:0] = 8'($urandom_range(0, 15));
        case ($urandom_range(0, 3))
            0:       a[15:8] = 8'h00;
            1:       a[15:8] = 8'hFF;
            2:       a[15:8] = 8'h80;
            default: ;
        endcase
        return a;
    endfunction

    function automatic void queue_random_instr();
        logic [7:0]  op;
        logic [15:0] target;
        op = KNOWN_OPS[$urandom_range(0, 20)];
        if ($urandom_range(0, 99) < 8)
            op = 8'($urandom);
        target = hot_address();
        // immediates often at the flag corners
        if ($urandom_range(0, 3) == 0)
        begin
            case ($urandom_range(0, 2))
                0:       target[7:0] = 8'h00;
                1:       target[7:0] = 8'h80;
                default: target[7:0] = 8'hFF;
            endcase
        end
        queue_instr(op, target[7:0], target[15:8]);
    endfunction

    function automatic void queue_random_step();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            queue_random_instr();
        else if (roll < 80)
            queue_request(MODE_WRITE, hot_address(), 8'($urandom));
        else if (roll < 90)
            queue_request(MODE_READ, hot_address(), 8'($urandom));
        else if (roll < 95)
            queue_request(MODE_EXEC, 16'($urandom), 8'($urandom));
        else
            queue_request(MODE_UNUSED, 16'($urandom), 8'($urandom));
    endfunction

    // sender pause until every result is back
    task automatic wait_drained();
        while (request_q.size() != 0 || due_results_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic compare_registers(input out_t got, input out_t want);
        if (got.read_data !== want.read_data)
            flag_error($sformatf("result %0d read_data %0h, expected %0h",
                                 result_count, got.read_data, want.read_data));
        if (got.status !== want.status)
            flag_error($sformatf("result %0d status %0h, expected %0h",
                                 result_count, got.status, want.status));
        if (got.acc_value !== want.acc_value)
            flag_error($sformatf("result %0d acc_value %0h, expected %0h",
                                 result_count, got.acc_value, want.acc_value));
        if (got.index_x_value !== want.index_x_value)
            flag_error($sformatf("result %0d index_x_value %0h, expected %0h",
                                 result_count, got.index_x_value, want.index_x_value));
        if (got.index_y_value !== want.index_y_value)
            flag_error($sformatf("result %0d index_y_value %0h, expected %0h",
                                 result_count, got.index_y_value, want.index_y_value));
        if (got.stack_value !== want.stack_value)
            flag_error($sformatf("result %0d stack_value %0h, expected %0h",
                                 result_count, got.stack_value, want.stack_value));
        if (got.program_counter !== want.program_counter)
            flag_error($sformatf("result %0d program_counter %0h, expected %0h",
                                 result_count, got.program_counter, want.program_counter));
        if (got.negative_flag !== want.negative_flag)
            flag_error($sformatf("result %0d negative_flag %0h, expected %0h",
                                 result_count, got.negative_flag, want.negative_flag));
        if (got.zero_flag !== want.zero_flag)
            flag_error($sformatf("result %0d zero_flag %0h, expected %0h",
                                 result_count, got.zero_flag, want.zero_flag));
    endtask

    // stimulus phases
    initial
    begin
        int k;
        for (k = 0; k < 65536; k++)
            cpu_mem[k] = 8'h00;
        cpu_a  = 8'h00;
        cpu_x  = 8'h00;
        cpu_y  = 8'h00;
        cpu_s  = 8'h00;
        cpu_pc = 16'h0000;
        cpu_n  = 1'b0;
        cpu_z  = 1'b0;

        // directed: ignored mode, unknown opcode on cleared memory, top address
        queue_request(MODE_UNUSED, 16'hFFFF, 8'hFF);
        queue_request(MODE_EXEC, 16'h0000, 8'h00);
        queue_request(MODE_WRITE, 16'hFFFF, 8'h80);
        queue_request(MODE_READ, 16'hFFFF, 8'h00);
        // loads and transfers, stack pointer copy keeps the flags
        queue_instr(OP_LDA_ABS, 8'hFF, 8'hFF);
        queue_instr(OP_TAX, 8'h00, 8'h00);
        queue_instr(OP_LDA_IMM, 8'h00, 8'h00);
        queue_instr(OP_TXS, 8'h00, 8'h00);
        queue_instr(OP_TSX, 8'h00, 8'h00);
        // store to zero page and load it back
        queue_instr(OP_STX_ZP, 8'hFE, 8'h00);
        queue_instr(OP_LDY_ZP, 8'hFE, 8'h00);
        queue_instr(OP_TYA, 8'h00, 8'h00);
        queue_request(MODE_READ, 16'h00FE, 8'h00);
        wait_drained();

        // random programs, with a full drain between the two parts
        while (queued_count < PART_A_END)
            queue_random_step();
        wait_drained();
        while (queued_count < PART_B_END)
            queue_random_step();
        wait_drained();

        // let any stray result show up
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                due_results_q.push_back(request_q[0].result);
                void'(request_q.pop_front());
                accepted_count <= accepted_count + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (request_q.size() != 0 &&
                    ((accepted_count >= 500 && accepted_count < 800) ||
                     $urandom_range(0, 99) >= 20))
                begin
                    in_valid <= 1'b1;
                    in_data  <= request_q[0].req;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result back-pressure, with one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (holdoff_left != 0)
        begin
            holdoff_left <= holdoff_left - 1;
            out_ready    <= 1'b0;
        end
        else if (!holdoff_done && result_count >= 1000)
        begin
            holdoff_left <= 400;
            holdoff_done <= 1'b1;
            out_ready    <= 1'b0;
        end
        else
            out_ready <= (result_count >= 500 && result_count < 800) ||
                         $urandom_range(0, 99) >= 20;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (due_results_q.size() == 0)
                flag_error($sformatf("result %0d arrived with no request outstanding",
                                     result_count));
            else
                compare_registers(out_data, due_results_q.pop_front());
            result_count <= result_count + 1;
        end
    end

    // hang watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

endmodule
